[hdl/ldbp_pkg.sv]
// Shared types and constants of the landmark depth back-projection block.
package ldbp_pkg;

   localparam int MAX_COLS_DEF      = 128;
   localparam int MAX_ROWS_DEF      = 128;
   localparam int WINDOW_RADIUS_DEF = 3;

   localparam logic [15:0] DEPTH_LOW  = 16'd1600;
   localparam logic [15:0] DEPTH_HIGH = 16'd16000;
   localparam logic [11:0] QUAL_BASE  = 12'd2560;
   localparam logic [8:0]  CONF_MAX   = 9'd256;

   // Shared divide / square-root unit widths.
   localparam int DW     = 48;
   localparam int REM_W  = 26;
   localparam int SH_W   = 28;
   localparam int STEP_W = 6;
   localparam int DIV_W  = 18;

   localparam int SUM_W  = 39;
   localparam int CNT_W  = 7;
   localparam int SIZE_W = 11;

   localparam logic [2:0] REG_FOCAL_X   = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
   localparam logic [2:0] REG_CENTER_X  = 3'd2;
   localparam logic [2:0] REG_CENTER_Y  = 3'd3;
   localparam logic [2:0] REG_MIN_DEPTH = 3'd4;
   localparam logic [2:0] REG_MAP_COLS  = 3'd5;
   localparam logic [2:0] REG_MAP_ROWS  = 3'd6;

   localparam logic [15:0] FOCAL_RESET = 16'd8192;
   localparam logic [7:0]  MAP_RESET   = 8'd128;

   typedef struct packed {
      logic                start;
      logic                sqrt_mode;
      logic [STEP_W-1:0]   steps;
   } iter_cmd_type;

endpackage

[hdl/landmark_depth_back_projection.sv]
// Top level of the landmark depth back-projection block.
// Usage: the req_ channel carries depth writes (op 0) and landmark queries (op 1).
// A write gives no result beat. A query gives exactly one rsp_ beat. A query whose
// rounded pixel is outside the map goes straight to the output state, one whose
// centre depth fails the checks goes there after the centre read. A valid query
// walks the (2*WINDOW_RADIUS+1)^2 window through the single-port depth memory
// one entry a cycle, then runs a 47-step divide, a 24-step square root and two
// 32-step divides on the shared iterative unit. Items are taken one at a time;
// req_stall is high while a query is in work. The result sits in an output
// register, so new items are taken while a finished beat waits on rsp_stall; a
// query that finishes while the output register is still held waits for it to
// drain.
// Reset clears the control state and loads register defaults; the depth memory
// is not cleared and holds no meaning until written.
// Configuration registers sit at byte addresses 4*i on the APB-style port.
module landmark_depth_back_projection #(
   parameter int MAX_COLS      = ldbp_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS      = ldbp_pkg::MAX_ROWS_DEF,
   parameter int WINDOW_RADIUS = ldbp_pkg::WINDOW_RADIUS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [6:0]         req_pixel_col,
   input  logic [6:0]         req_pixel_row,
   input  logic [15:0]        req_depth_value,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic [8:0]         req_point_conf,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [13:0]        rsp_pos_z,
   output logic [8:0]         rsp_out_conf,
   output logic [8:0]         rsp_quality,
   output logic               rsp_valid_res,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PXW   = CW + 2;
   localparam int PYW   = RW + 2;
   localparam int OFS_W = $clog2(WINDOW_RADIUS + 1) + 1;
   localparam logic [AW-1:0]           COLS_A = AW'(MAX_COLS);
   localparam logic signed [OFS_W-1:0] R_POS  = OFS_W'(WINDOW_RADIUS);
   localparam logic signed [OFS_W-1:0] R_NEG  = -OFS_W'(WINDOW_RADIUS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CTR_RD, ST_CTR_CHK, ST_WIN, ST_DRAIN, ST_DIV_GO, ST_DIV_WAIT,
      ST_SQRT_GO, ST_SQRT_WAIT, ST_PRJ_MUL, ST_PRJ_GO, ST_PRJ_WAIT, ST_OUT
   } state_type;

   state_type state_ff;

   logic [15:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff, min_depth_ff;
   logic [7:0]  map_cols_ff, map_rows_ff;

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_ff;

   logic [CW-1:0]           x_ff;
   logic [RW-1:0]           y_ff;
   logic [15:0]             d_ff;
   logic [8:0]              conf_ff;
   logic [8:0]              qual_ff;
   logic                    ok_ff;
   logic signed [OFS_W-1:0] dx_ff, dy_ff;
   logic                    drn_ff;
   logic                    win_v_ff, sq_v_ff;
   logic [31:0]             sq_ff;
   logic [ldbp_pkg::SUM_W-1:0] sum_ff;
   logic [ldbp_pkg::CNT_W-1:0] count_ff;
   logic                    axis_ff;
   logic [30:0]             prod_ff;
   logic                    neg_ff;
   logic [31:0]             px_ff, py_ff;

   logic                    rsp_valid_ff;
   logic [31:0]             rsp_x_ff, rsp_y_ff;
   logic [13:0]             rsp_z_ff;
   logic [8:0]              rsp_conf_ff, rsp_qual_ff;
   logic                    rsp_ok_ff;

   logic                    req_take, cfg_wr;
   logic [ldbp_pkg::SIZE_W-1:0] cols_eff, rows_eff;
   logic [16:0]             ax, ay;
   logic [12:0]             rx, ry;
   logic                    in_map;
   logic [8:0]              conf_sat;
   logic signed [PXW-1:0]   px_s;
   logic signed [PYW-1:0]   py_s;
   logic                    win_in_map;
   logic [AW-1:0]           wr_addr, ctr_addr, win_addr, mem_addr;
   logic                    mem_we;
   logic                    d_bad;
   logic [15:0]             nd_mag;
   logic [11:0]             qdiff;
   logic [8:0]              qshift;
   logic [17:0]             nb;
   logic [16:0]             nb_mag;
   logic [15:0]             focal_sel, focal_nz;
   logic [31:0]             prj_num;
   logic [31:0]             q_sgn;

   ldbp_pkg::iter_cmd_type     it_cmd;
   logic [ldbp_pkg::DW-1:0]    it_operand, it_result;
   logic [ldbp_pkg::DIV_W-1:0] it_divisor;
   logic                       it_busy;

   ldbp_iter u_iter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (it_cmd),
      .operand (it_operand),
      .divisor (it_divisor),
      .busy    (it_busy),
      .result  (it_result)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[4:2])
         ldbp_pkg::REG_FOCAL_X:   prdata = 32'(focal_x_ff);
         ldbp_pkg::REG_FOCAL_Y:   prdata = 32'(focal_y_ff);
         ldbp_pkg::REG_CENTER_X:  prdata = 32'(center_x_ff);
         ldbp_pkg::REG_CENTER_Y:  prdata = 32'(center_y_ff);
         ldbp_pkg::REG_MIN_DEPTH: prdata = 32'(min_depth_ff);
         ldbp_pkg::REG_MAP_COLS:  prdata = 32'(map_cols_ff);
         ldbp_pkg::REG_MAP_ROWS:  prdata = 32'(map_rows_ff);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= ldbp_pkg::FOCAL_RESET;
         focal_y_ff   <= ldbp_pkg::FOCAL_RESET;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         min_depth_ff <= '0;
         map_cols_ff  <= ldbp_pkg::MAP_RESET;
         map_rows_ff  <= ldbp_pkg::MAP_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            ldbp_pkg::REG_FOCAL_X:   focal_x_ff   <= pwdata[15:0];
            ldbp_pkg::REG_FOCAL_Y:   focal_y_ff   <= pwdata[15:0];
            ldbp_pkg::REG_CENTER_X:  center_x_ff  <= pwdata[15:0];
            ldbp_pkg::REG_CENTER_Y:  center_y_ff  <= pwdata[15:0];
            ldbp_pkg::REG_MIN_DEPTH: min_depth_ff <= pwdata[15:0];
            ldbp_pkg::REG_MAP_COLS:  map_cols_ff  <= pwdata[7:0];
            ldbp_pkg::REG_MAP_ROWS:  map_rows_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cols_eff = (ldbp_pkg::SIZE_W'(map_cols_ff) < ldbp_pkg::SIZE_W'(MAX_COLS))
               ? ldbp_pkg::SIZE_W'(map_cols_ff) : ldbp_pkg::SIZE_W'(MAX_COLS);
      rows_eff = (ldbp_pkg::SIZE_W'(map_rows_ff) < ldbp_pkg::SIZE_W'(MAX_ROWS))
               ? ldbp_pkg::SIZE_W'(map_rows_ff) : ldbp_pkg::SIZE_W'(MAX_ROWS);

      // Round half away from zero on the magnitude; a negative pixel that rounds
      // to zero still lands on column or row zero.
      ax = req_point_x[15] ? 17'(-{1'b1, req_point_x}) : 17'({1'b0, req_point_x});
      ay = req_point_y[15] ? 17'(-{1'b1, req_point_y}) : 17'({1'b0, req_point_y});
      rx = 13'((ax + 17'd8) >> 4);
      ry = 13'((ay + 17'd8) >> 4);
      in_map = (!req_point_x[15] || rx == '0) && (13'(cols_eff) > rx)
            && (!req_point_y[15] || ry == '0) && (13'(rows_eff) > ry);
      conf_sat = (req_point_conf > ldbp_pkg::CONF_MAX) ? ldbp_pkg::CONF_MAX : req_point_conf;

      px_s = $signed({2'b00, x_ff}) + PXW'(dx_ff);
      py_s = $signed({2'b00, y_ff}) + PYW'(dy_ff);
      win_in_map = !px_s[PXW-1] && !py_s[PYW-1]
                && (ldbp_pkg::SIZE_W'(px_s[PXW-2:0]) < cols_eff)
                && (ldbp_pkg::SIZE_W'(py_s[PYW-2:0]) < rows_eff);

      wr_addr  = AW'(req_pixel_row) * COLS_A + AW'(req_pixel_col);
      ctr_addr = AW'(y_ff) * COLS_A + AW'(x_ff);
      win_addr = AW'(py_s[RW-1:0]) * COLS_A + AW'(px_s[CW-1:0]);
      unique case (state_ff)
         ST_IDLE:   mem_addr = wr_addr;
         ST_CTR_RD: mem_addr = ctr_addr;
         default:   mem_addr = win_addr;
      endcase
      mem_we = req_take && !req_op
            && (ldbp_pkg::SIZE_W'(req_pixel_col) < ldbp_pkg::SIZE_W'(MAX_COLS))
            && (ldbp_pkg::SIZE_W'(req_pixel_row) < ldbp_pkg::SIZE_W'(MAX_ROWS));

      d_bad  = (rd_ff <= min_depth_ff) || (rd_ff < ldbp_pkg::DEPTH_LOW)
            || (rd_ff > ldbp_pkg::DEPTH_HIGH);
      nd_mag = (rd_ff > d_ff) ? rd_ff - d_ff : d_ff - rd_ff;

      qdiff  = ldbp_pkg::QUAL_BASE - it_result[11:0];
      qshift = 9'(qdiff >> 3);

      nb = axis_ff ? 18'({y_ff, 4'b0000}) - 18'(center_y_ff)
                   : 18'({x_ff, 4'b0000}) - 18'(center_x_ff);
      nb_mag    = nb[17] ? 17'(-nb) : nb[16:0];
      focal_sel = axis_ff ? focal_y_ff : focal_x_ff;
      focal_nz  = (focal_sel == '0) ? 16'd1 : focal_sel;
      prj_num   = {prod_ff, 1'b0} + 32'(focal_nz);
      q_sgn     = neg_ff ? -it_result[31:0] : it_result[31:0];

      it_cmd     = '0;
      it_operand = '0;
      it_divisor = '0;
      unique case (state_ff)
         ST_DIV_GO: begin
            it_cmd.start = 1'b1;
            it_cmd.steps = ldbp_pkg::STEP_W'(ldbp_pkg::SUM_W + 8);
            it_operand   = {sum_ff, 8'h00, 1'b0};
            it_divisor   = (count_ff == '0) ? ldbp_pkg::DIV_W'(1)
                                            : ldbp_pkg::DIV_W'(count_ff);
         end
         ST_SQRT_GO: begin
            it_cmd.start     = 1'b1;
            it_cmd.sqrt_mode = 1'b1;
            it_cmd.steps     = ldbp_pkg::STEP_W'(ldbp_pkg::DW / 2);
            it_operand       = it_result;
         end
         ST_PRJ_GO: begin
            it_cmd.start = 1'b1;
            it_cmd.steps = ldbp_pkg::STEP_W'(32);
            it_operand   = {prj_num, 16'h0000};
            it_divisor   = ldbp_pkg::DIV_W'({focal_nz, 1'b0});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_depth_value;
      end
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         win_v_ff     <= 1'b0;
         sq_v_ff      <= 1'b0;
      end else begin
         // The window read pipeline: address, data, square, accumulate.
         win_v_ff <= (state_ff == ST_WIN) && win_in_map;
         sq_v_ff  <= win_v_ff && (rd_ff != '0);
         sq_ff    <= 32'(nd_mag) * 32'(nd_mag);
         if (sq_v_ff) begin
            sum_ff   <= sum_ff + ldbp_pkg::SUM_W'(sq_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take && req_op) begin
                  x_ff    <= rx[CW-1:0];
                  y_ff    <= ry[RW-1:0];
                  conf_ff <= conf_sat;
                  ok_ff   <= in_map;
                  state_ff <= in_map ? ST_CTR_RD : ST_OUT;
               end
            end
            ST_CTR_RD: state_ff <= ST_CTR_CHK;
            ST_CTR_CHK: begin
               d_ff     <= rd_ff;
               dx_ff    <= R_NEG;
               dy_ff    <= R_NEG;
               sum_ff   <= '0;
               count_ff <= '0;
               if (d_bad) begin
                  ok_ff    <= 1'b0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_WIN;
               end
            end
            ST_WIN: begin
               if (dx_ff == R_POS) begin
                  dx_ff <= R_NEG;
                  if (dy_ff == R_POS) begin
                     drn_ff   <= 1'b0;
                     state_ff <= ST_DRAIN;
                  end else begin
                     dy_ff <= dy_ff + 1'b1;
                  end
               end else begin
                  dx_ff <= dx_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               drn_ff <= 1'b1;
               if (drn_ff) begin
                  state_ff <= ST_DIV_GO;
               end
            end
            ST_DIV_GO:   state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (!it_busy) begin
                  state_ff <= ST_SQRT_GO;
               end
            end
            ST_SQRT_GO:  state_ff <= ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
               if (!it_busy) begin
                  if (it_result >= ldbp_pkg::DW'(ldbp_pkg::QUAL_BASE)) begin
                     qual_ff <= '0;
                  end else begin
                     qual_ff <= (qshift > ldbp_pkg::CONF_MAX) ? ldbp_pkg::CONF_MAX : qshift;
                  end
                  axis_ff  <= 1'b0;
                  state_ff <= ST_PRJ_MUL;
               end
            end
            ST_PRJ_MUL: begin
               prod_ff  <= 31'(nb_mag) * 31'(d_ff[13:0]);
               neg_ff   <= nb[17];
               state_ff <= ST_PRJ_GO;
            end
            ST_PRJ_GO: state_ff <= ST_PRJ_WAIT;
            ST_PRJ_WAIT: begin
               if (!it_busy) begin
                  if (axis_ff) begin
                     py_ff    <= q_sgn;
                     state_ff <= ST_OUT;
                  end else begin
                     px_ff    <= q_sgn;
                     axis_ff  <= 1'b1;
                     state_ff <= ST_PRJ_MUL;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ok_ff    <= ok_ff;
                  rsp_x_ff     <= ok_ff ? px_ff : '0;
                  rsp_y_ff     <= ok_ff ? py_ff : '0;
                  rsp_z_ff     <= ok_ff ? d_ff[13:0] : '0;
                  rsp_conf_ff  <= ok_ff ? conf_ff : '0;
                  rsp_qual_ff  <= ok_ff ? qual_ff : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = $signed(rsp_x_ff);
   assign rsp_pos_y     = $signed(rsp_y_ff);
   assign rsp_pos_z     = rsp_z_ff;
   assign rsp_out_conf  = rsp_conf_ff;
   assign rsp_quality   = rsp_qual_ff;
   assign rsp_valid_res = rsp_ok_ff;

endmodule

[hdl/ldbp_iter.sv]
// Shared iterative unit: restoring divide one bit a cycle, square root two bits a cycle.
module ldbp_iter (
   input  logic                         clock,
   input  logic                         reset,
   input  ldbp_pkg::iter_cmd_type       cmd,
   input  logic [ldbp_pkg::DW-1:0]      operand,
   input  logic [ldbp_pkg::DIV_W-1:0]   divisor,
   output logic                         busy,
   output logic [ldbp_pkg::DW-1:0]      result
);

   logic [ldbp_pkg::STEP_W-1:0] cnt_ff;
   logic                        mode_ff;
   logic [ldbp_pkg::DW-1:0]     op_ff;
   logic [ldbp_pkg::DW-1:0]     res_ff;
   logic [ldbp_pkg::REM_W-1:0]  rem_ff;
   logic [ldbp_pkg::DIV_W-1:0]  div_ff;

   logic [ldbp_pkg::SH_W-1:0]   shifted;
   logic [ldbp_pkg::SH_W-1:0]   trial;
   logic [ldbp_pkg::SH_W:0]     diff;
   logic                        ge;

   // The operand is left-aligned, so each step brings in its top one or two bits.
   always_comb begin
      if (mode_ff) begin
         shifted = {rem_ff, op_ff[ldbp_pkg::DW-1 -: 2]};
         trial   = ldbp_pkg::SH_W'({res_ff[ldbp_pkg::REM_W-3:0], 2'b01});
      end else begin
         shifted = {1'b0, rem_ff, op_ff[ldbp_pkg::DW-1]};
         trial   = ldbp_pkg::SH_W'(div_ff);
      end
      diff = {1'b0, shifted} - {1'b0, trial};
      ge   = !diff[ldbp_pkg::SH_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= cmd.steps;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= cmd.sqrt_mode;
         op_ff   <= operand;
         div_ff  <= divisor;
         rem_ff  <= '0;
         res_ff  <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= ge ? diff[ldbp_pkg::REM_W-1:0] : shifted[ldbp_pkg::REM_W-1:0];
         res_ff <= {res_ff[ldbp_pkg::DW-2:0], ge};
         op_ff  <= mode_ff ? {op_ff[ldbp_pkg::DW-3:0], 2'b00}
                           : {op_ff[ldbp_pkg::DW-2:0], 1'b0};
      end
   end

   assign busy   = cnt_ff != '0;
   assign result = res_ff;

endmodule

[verif/tb_landmark_depth_back_projection.sv]
// Self-checking testbench of the landmark depth back-projection block.
`timescale 1ns / 100ps

module tb_landmark_depth_back_projection;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;
   localparam int   STORE_COLS = 128;
   localparam int   STORE_ROWS = 128;
   localparam int   RADIUS = 3;
   localparam int   FILL_SIZE = 16;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [13:0]        pos_z;
      logic [8:0]         out_conf;
      logic [8:0]         quality;
      logic               valid_res;
   } landmark_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_op = OP_WRITE;
   logic [6:0]         req_pixel_col = '0;
   logic [6:0]         req_pixel_row = '0;
   logic [15:0]        req_depth_value = '0;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic [8:0]         req_point_conf = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic [13:0]        rsp_pos_z;
   logic [8:0]         rsp_out_conf;
   logic [8:0]         rsp_quality;
   logic               rsp_valid_res;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   landmark_depth_back_projection dut (.*);

   // Local copy of the block state used for prediction.
   logic [15:0] depth_mirror [0:STORE_COLS*STORE_ROWS-1];
   bit          depth_written [0:STORE_COLS*STORE_ROWS-1];
   int unsigned focal_x_cfg, focal_y_cfg, center_x_cfg, center_y_cfg;
   int unsigned min_depth_cfg, map_cols_cfg, map_rows_cfg;

   landmark_result_type pending_results[$];
   int   error_count = 0;
   bit   calm = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] project_axis(int pix, int unsigned center,
                                                int unsigned focal, int unsigned d);
      longint          num;
      longint unsigned f, mag, q;
      num = (longint'(pix) * 16 - longint'(center)) * longint'(d);
      f = (focal == 0) ? 1 : focal;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + f) / (2 * f);
      if (q > 64'd2147483647) q = (num < 0) ? 64'd2147483648 : 64'd2147483647;
      return (num < 0) ? 32'(-longint'(q)) : 32'(q);
   endfunction

   function automatic int round_pixel(logic signed [15:0] v);
      int a;
      a = (v < 0) ? -int'(v) : int'(v);
      a = (a + 8) >>> 4;
      return (v < 0) ? -a : a;
   endfunction

   function automatic landmark_result_type back_project(logic signed [15:0] px16,
                                                        logic signed [15:0] py16,
                                                        logic [8:0] conf);
      landmark_result_type res;
      int              cols, rows, x, y, wx, wy;
      int unsigned     d, n, count;
      longint          diff, qv;
      longint unsigned sum;
      res = '{0, 0, 0, 0, 0, 0};
      cols = (map_cols_cfg < STORE_COLS) ? map_cols_cfg : STORE_COLS;
      rows = (map_rows_cfg < STORE_ROWS) ? map_rows_cfg : STORE_ROWS;
      x = round_pixel(px16);
      y = round_pixel(py16);
      if (x < 0 || x >= cols || y < 0 || y >= rows) return res;
      d = depth_mirror[y * STORE_COLS + x];
      if (d <= min_depth_cfg || d < 1600 || d > 16000) return res;
      sum = 0;
      count = 0;
      for (wy = y - RADIUS; wy <= y + RADIUS; wy++) begin
         for (wx = x - RADIUS; wx <= x + RADIUS; wx++) begin
            if (wx < 0 || wx >= cols || wy < 0 || wy >= rows) continue;
            n = depth_mirror[wy * STORE_COLS + wx];
            if (n == 0) continue;
            diff = longint'(n) - longint'(d);
            sum += diff * diff;
            count++;
         end
      end
      if (count == 0) count = 1;
      qv = (2560 - longint'(int_sqrt((sum * 256) / count))) / 8;
      if (qv < 0) qv = 0;
      if (qv > 256) qv = 256;
      res.pos_x = project_axis(x, center_x_cfg, focal_x_cfg, d);
      res.pos_y = project_axis(y, center_y_cfg, focal_y_cfg, d);
      res.pos_z = d[13:0];
      res.out_conf = (conf > 256) ? 9'd256 : conf;
      res.quality = qv[8:0];
      res.valid_res = 1'b1;
      return res;
   endfunction

   // Mostly smooth plausible depths, with holes, outliers and range edges mixed in.
   function automatic logic [15:0] pick_depth();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'($urandom);
         2: begin
            case ($urandom_range(0, 5))
               0: return 16'd1599;
               1: return 16'd1600;
               2: return 16'd16000;
               3: return 16'd16001;
               4: return 16'hFFFF;
               default: return 16'd1;
            endcase
         end
         default: return 16'(4000 + $urandom_range(0, 2000));
      endcase
   endfunction

   // Sends one beat; valid stays high so back-to-back beats need no extra edge.
   task automatic send_item(logic op, logic [6:0] col, logic [6:0] row, logic [15:0] depth,
                            logic signed [15:0] px, logic signed [15:0] py, logic [8:0] conf);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= op;
      req_pixel_col <= col;
      req_pixel_row <= row;
      req_depth_value <= depth;
      req_point_x <= px;
      req_point_y <= py;
      req_point_conf <= conf;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (op == OP_WRITE) begin
         depth_mirror[row * STORE_COLS + col] = depth;
         depth_written[row * STORE_COLS + col] = 1'b1;
      end else begin
         pending_results.push_back(back_project(px, py, conf));
      end
   endtask

   task automatic write_depth(int col, int row, logic [15:0] depth);
      send_item(OP_WRITE, col[6:0], row[6:0], depth, 16'($urandom), 16'($urandom),
                9'($urandom));
   endtask

   task automatic query_point(logic signed [15:0] px, logic signed [15:0] py,
                              logic [8:0] conf);
      int cols, rows, x, y;
      cols = (map_cols_cfg < STORE_COLS) ? map_cols_cfg : STORE_COLS;
      rows = (map_rows_cfg < STORE_ROWS) ? map_rows_cfg : STORE_ROWS;
      x = round_pixel(px);
      y = round_pixel(py);
      // Every in-map pixel of the window gets a depth before the query can read it.
      if (x >= 0 && x < cols && y >= 0 && y < rows) begin
         for (int wy = y - RADIUS; wy <= y + RADIUS; wy++)
            for (int wx = x - RADIUS; wx <= x + RADIUS; wx++)
               if (wx >= 0 && wx < cols && wy >= 0 && wy < rows
                   && !depth_written[wy * STORE_COLS + wx])
                  write_depth(wx, wy, pick_depth());
      end
      send_item(OP_QUERY, 7'($urandom), 7'($urandom), 16'($urandom), px, py, conf);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         ldbp_pkg::REG_FOCAL_X:   focal_x_cfg = value[15:0];
         ldbp_pkg::REG_FOCAL_Y:   focal_y_cfg = value[15:0];
         ldbp_pkg::REG_CENTER_X:  center_x_cfg = value[15:0];
         ldbp_pkg::REG_CENTER_Y:  center_y_cfg = value[15:0];
         ldbp_pkg::REG_MIN_DEPTH: min_depth_cfg = value[15:0];
         ldbp_pkg::REG_MAP_COLS:  map_cols_cfg = value[7:0];
         ldbp_pkg::REG_MAP_ROWS:  map_rows_cfg = value[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(int fx, int fy, int cx, int cy, int md, int mc, int mr);
      drain();
      csr_write(ldbp_pkg::REG_FOCAL_X, fx);
      csr_write(ldbp_pkg::REG_FOCAL_Y, fy);
      csr_write(ldbp_pkg::REG_CENTER_X, cx);
      csr_write(ldbp_pkg::REG_CENTER_Y, cy);
      csr_write(ldbp_pkg::REG_MIN_DEPTH, md);
      csr_write(ldbp_pkg::REG_MAP_COLS, mc);
      csr_write(ldbp_pkg::REG_MAP_ROWS, mr);
   endtask

   function automatic logic signed [15:0] pick_coord(int size);
      if (size <= 0) size = 1;
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(0, size - 1)) * 16 + int'($urandom_range(0, 15)) - 8);
   endfunction

   // Queries stay mostly near the filled corner so few extra writes are needed.
   task automatic random_item;
      int cols, rows;
      cols = (map_cols_cfg < FILL_SIZE) ? map_cols_cfg : FILL_SIZE;
      rows = (map_rows_cfg < FILL_SIZE) ? map_rows_cfg : FILL_SIZE;
      if ($urandom_range(0, 9) < 4) write_depth($urandom_range(0, 127), $urandom_range(0, 127),
                                                pick_depth());
      else query_point(pick_coord(cols), pick_coord(rows), 9'($urandom));
   endtask

   // Gives the corner where most queries land a depth everywhere up front.
   task automatic test_fill_store;
      for (int r = 0; r < FILL_SIZE; r++)
         for (int c = 0; c < FILL_SIZE; c++) write_depth(c, r, pick_depth());
   endtask

   task automatic test_directed;
      write_depth(10, 10, 16'd1600);
      write_depth(11, 10, 16'd1599);
      write_depth(12, 10, 16'd16000);
      write_depth(13, 10, 16'd16001);
      write_depth(14, 10, 16'd0);
      write_depth(127, 127, 16'd8000);
      write_depth(0, 0, 16'd5000);
      for (int c = 10; c <= 14; c++) query_point(16'(c * 16), 16'(160), 9'd200);
      query_point(16'd0, 16'd0, 9'd511);
      query_point(16'(127 * 16), 16'(127 * 16 + 7), 9'd256);
      query_point(16'(127 * 16 + 8), 16'(127 * 16), 9'd257);
      query_point(-16'sd8, 16'd0, 9'd0);
      query_point(-16'sd7, -16'sd7, 9'd128);
      query_point(16'sh7FFF, 16'sh7FFF, 9'd1);
      query_point(16'sh8000, 16'sh8000, 9'd255);
      query_point(16'd168, 16'd152, 9'd100);
      query_point(16'd167, 16'd153, 9'd100);
   endtask

   task automatic test_config_extremes;
      apply_config(0, 0, 65535, 65535, 0, 128, 128);
      repeat (60) random_item();
      apply_config(65535, 65535, 0, 0, 16000, 255, 255);
      repeat (60) random_item();
      apply_config(1, 1, 32768, 12345, 65535, 0, 0);
      repeat (30) random_item();
      apply_config(8192, 4096, 1000, 2000, 5000, 1, 1);
      query_point(16'd0, 16'd0, 9'd300);
      repeat (30) random_item();
      apply_config(2000, 3000, 900, 700, 1599, 8, 20);
      repeat (60) random_item();
   endtask

   task automatic test_random;
      for (int i = 0; i < 800; i++) begin
         if (i % 200 == 0) begin
            apply_config($urandom_range(1, 65535), $urandom_range(1, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 6000), $urandom_range(1, 128),
                         $urandom_range(1, 128));
         end
         if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         random_item();
      end
      calm = 0;
   endtask

   initial begin
      focal_x_cfg = ldbp_pkg::FOCAL_RESET;
      focal_y_cfg = ldbp_pkg::FOCAL_RESET;
      center_x_cfg = 0;
      center_y_cfg = 0;
      min_depth_cfg = 0;
      map_cols_cfg = ldbp_pkg::MAP_RESET;
      map_rows_cfg = ldbp_pkg::MAP_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_store();
      test_directed();
      test_config_extremes();
      test_random();
      drain();
      repeat (250) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: random stall per beat, sometimes none at all.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = calm ? 0 : $urandom_range(0, 13);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      landmark_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no query waiting");
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_pos_x !== exp_res.pos_x) begin
               $error("pos_x expected %0d got %0d", exp_res.pos_x, rsp_pos_x);
               error_count++;
            end
            if (rsp_pos_y !== exp_res.pos_y) begin
               $error("pos_y expected %0d got %0d", exp_res.pos_y, rsp_pos_y);
               error_count++;
            end
            if (rsp_pos_z !== exp_res.pos_z) begin
               $error("pos_z expected %0d got %0d", exp_res.pos_z, rsp_pos_z);
               error_count++;
            end
            if (rsp_out_conf !== exp_res.out_conf) begin
               $error("out_conf expected %0d got %0d", exp_res.out_conf, rsp_out_conf);
               error_count++;
            end
            if (rsp_quality !== exp_res.quality) begin
               $error("quality expected %0d got %0d", exp_res.quality, rsp_quality);
               error_count++;
            end
            if (rsp_valid_res !== exp_res.valid_res) begin
               $error("valid_res expected %0d got %0d", exp_res.valid_res, rsp_valid_res);
               error_count++;
            end
         end
      end
   end

endmodule
